// ===== rtl/binary_modular_inverse_defines.svh =====
// Assertion macros used by the modular inverse core RTL.
`ifndef BINARY_MODULAR_INVERSE_DEFINES_SVH
`define BINARY_MODULAR_INVERSE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BMI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmi assertion failed");

// Next-cycle implication, disabled while reset is low.
`define BMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmi assertion failed");

`endif

// ===== rtl/bmi_pkg.sv =====
// Package: shared types and constants of the binary modular inverse block.
`default_nettype none
package bmi_pkg;

  localparam int WORD_W        = 64;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 2;
  localparam int NUM_CFG       = 4;
  localparam int DEF_LIMBS     = 4;
  localparam int DEF_LIMB_BITS = 64;

  // Modulus reset value, least significant word first (2^255 - 19)
  localparam logic [CFG_DATA_W-1:0] MOD_RESET [NUM_CFG] = '{
    64'hFFFF_FFFF_FFFF_FFED, 64'hFFFF_FFFF_FFFF_FFFF,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF
  };

  typedef struct packed {
    logic [WORD_W-1:0] operand_word;
    logic              operand_last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] inverse_word;
    logic              inverse_last;
    logic              not_invertible;
  } out_item_t;

  // Core completion status
  typedef struct packed {
    logic done;
    logic fail;
  } bmi_status_t;

endpackage
`default_nettype wire

// ===== rtl/binary_modular_inverse.sv =====
// Operand words are accepted while idle; the last word starts the inversion.
// Inversion: each round runs a test, halvings of u or v, then compare, v - u if needed,
// x subtract and modulus fix-up if needed; all arithmetic uses one shared adder.
// Results: LIMBS words, one per cycle while out_ready is high; one item at a time.
// Reset (rst_n, synchronous): control state cleared, load index zero, modulus 2^255-19.
// No clearing pass after reset: the block is ready as soon as reset is released.
`default_nettype none
module binary_modular_inverse #(
  parameter int LIMBS     = bmi_pkg::DEF_LIMBS,
  parameter int LIMB_BITS = bmi_pkg::DEF_LIMB_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bmi_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bmi_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [bmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmi_pkg::*;

  localparam int N    = LIMBS * LIMB_BITS;
  localparam int IDXW = (LIMBS > 1) ? $clog2(LIMBS) : 1;

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_OUT  = 3'b100
  } top_state_t;

  top_state_t           tst_r, tst_nxt;
  logic [IDXW-1:0]      ld_idx_r, ld_idx_nxt;
  logic [IDXW-1:0]      cnt_r, cnt_nxt;
  logic                 nf_r, nf_nxt;
  logic [LIMB_BITS-1:0] lbuf_r [LIMBS];
  logic [LIMB_BITS-1:0] mod_r  [LIMBS];
  logic [N-1:0]         p_vec, u_load, x1;
  logic                 in_acc, start;
  bmi_status_t          sts;

  assign in_ready = (tst_r == T_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign start    = in_acc && in_data.operand_last;

  // Modulus registers and operand assembly
  for (genvar i = 0; i < LIMBS; i++) begin : g_limb
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mod_r[i] <= MOD_RESET[i][LIMB_BITS-1:0];
      end else if (cfg_we && (cfg_index == CFG_IDX_W'(i))) begin
        mod_r[i] <= cfg_data[LIMB_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (in_acc && (ld_idx_r == IDXW'(i))) begin
        lbuf_r[i] <= in_data.operand_word[LIMB_BITS-1:0];
      end
    end

    assign p_vec[i*LIMB_BITS +: LIMB_BITS] = mod_r[i];
    // Limbs above the last word read as zero
    assign u_load[i*LIMB_BITS +: LIMB_BITS] =
      (ld_idx_r == IDXW'(i)) ? in_data.operand_word[LIMB_BITS-1:0] :
      (ld_idx_r >  IDXW'(i)) ? lbuf_r[i] : '0;
  end

  bmi_core #(.N(N)) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (start),
    .u_load_i(u_load),
    .p_i     (p_vec),
    .sts_o   (sts),
    .x1_o    (x1)
  );

  // Load, run and result sequencing
  always_comb begin
    tst_nxt    = tst_r;
    ld_idx_nxt = ld_idx_r;
    cnt_nxt    = cnt_r;
    nf_nxt     = nf_r;
    case (tst_r)
      T_IDLE: begin
        if (in_acc) begin
          if (in_data.operand_last) begin
            ld_idx_nxt = '0;
            tst_nxt    = T_RUN;
          end else if (ld_idx_r == IDXW'(LIMBS - 1)) begin
            ld_idx_nxt = '0;
          end else begin
            ld_idx_nxt = ld_idx_r + IDXW'(1);
          end
        end
      end
      T_RUN: begin
        if (sts.done) begin
          nf_nxt  = sts.fail;
          cnt_nxt = '0;
          tst_nxt = T_OUT;
        end
      end
      T_OUT: begin
        if (out_ready) begin
          if (cnt_r == IDXW'(LIMBS - 1)) begin
            tst_nxt = T_IDLE;
          end else begin
            cnt_nxt = cnt_r + IDXW'(1);
          end
        end
      end
      default: begin
        tst_nxt = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tst_r    <= T_IDLE;
      ld_idx_r <= '0;
      cnt_r    <= '0;
      nf_r     <= 1'b0;
    end else begin
      tst_r    <= tst_nxt;
      ld_idx_r <= ld_idx_nxt;
      cnt_r    <= cnt_nxt;
      nf_r     <= nf_nxt;
    end
  end

  // Result words come from the held x1 register
  assign out_valid = (tst_r == T_OUT);
  always_comb begin
    out_data                = '0;
    out_data.inverse_word   = nf_r ? '0 : WORD_W'(x1[cnt_r*LIMB_BITS +: LIMB_BITS]);
    out_data.inverse_last   = (cnt_r == IDXW'(LIMBS - 1));
    out_data.not_invertible = nf_r;
  end

endmodule
`default_nettype wire

// ===== rtl/bmi_addsub.sv =====
// Shared wide adder/subtractor with carry or borrow out.
`default_nettype none
module bmi_addsub #(
  parameter int W = 256
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output logic         cout_o   // carry for add, borrow for subtract
);
  logic [W-1:0] b_x;
  logic         c_raw;

  assign b_x = sub_i ? ~b_i : b_i;
  assign {c_raw, sum_o} = {1'b0, a_i} + {1'b0, b_x} + {{W{1'b0}}, sub_i};
  assign cout_o = sub_i ? ~c_raw : c_raw;

endmodule
`default_nettype wire

// ===== rtl/bmi_core.sv =====
// Sequencer and u/v/x1/x2 registers of the binary extended Euclid loop.
`default_nettype none
`include "binary_modular_inverse_defines.svh"
module bmi_core #(
  parameter int N = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start_i,
  input  logic [N-1:0]         u_load_i,
  input  logic [N-1:0]         p_i,
  output bmi_pkg::bmi_status_t sts_o,
  output logic [N-1:0]         x1_o
);
  import bmi_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_TEST    = 8'b0000_0010,
    S_HALVE_U = 8'b0000_0100,
    S_HALVE_V = 8'b0000_1000,
    S_CMP     = 8'b0001_0000,
    S_SUBVU   = 8'b0010_0000,
    S_XSUB    = 8'b0100_0000,
    S_XFIX    = 8'b1000_0000
  } state_t;

  localparam logic [N-1:0] ONE = N'(1);

  state_t       st_r, st_nxt;
  logic [N-1:0] u_r, u_nxt, v_r, v_nxt, x1_r, x1_nxt, x2_r, x2_nxt;
  logic         dir_r, dir_nxt;   // 0: x1 -= x2, 1: x2 -= x1
  logic [N-1:0] op_a, op_b, sum;
  logic         op_sub, cout;
  logic         u_one, v_one, u_zero, v_zero;

  // Shared arithmetic unit
  bmi_addsub #(.W(N)) u_addsub (
    .a_i   (op_a),
    .b_i   (op_b),
    .sub_i (op_sub),
    .sum_o (sum),
    .cout_o(cout)
  );

  // Whole-value stop tests
  assign u_one  = (u_r == ONE);
  assign v_one  = (v_r == ONE);
  assign u_zero = (u_r == '0);
  assign v_zero = (v_r == '0);

  // Sequencer
  always_comb begin
    st_nxt  = st_r;
    u_nxt   = u_r;
    v_nxt   = v_r;
    x1_nxt  = x1_r;
    x2_nxt  = x2_r;
    dir_nxt = dir_r;
    op_a    = x1_r;
    op_b    = '0;
    op_sub  = 1'b0;
    sts_o   = '0;
    case (st_r)
      S_IDLE: begin
        if (start_i) begin
          u_nxt  = u_load_i;
          v_nxt  = p_i;
          x1_nxt = ONE;
          x2_nxt = '0;
          st_nxt = S_TEST;
        end
      end
      S_TEST: begin
        if (u_one) begin
          sts_o.done = 1'b1;
          st_nxt     = S_IDLE;
        end else if (v_one) begin
          x1_nxt     = x2_r;
          sts_o.done = 1'b1;
          st_nxt     = S_IDLE;
        end else if (u_zero || v_zero) begin
          sts_o.done = 1'b1;
          sts_o.fail = 1'b1;
          st_nxt     = S_IDLE;
        end else if (!u_r[0]) begin
          st_nxt = S_HALVE_U;
        end else if (!v_r[0]) begin
          st_nxt = S_HALVE_V;
        end else begin
          st_nxt = S_CMP;
        end
      end
      // u/2 and (x1 [+p])/2 keeping the carry
      S_HALVE_U: begin
        op_a   = x1_r;
        op_b   = x1_r[0] ? p_i : '0;
        u_nxt  = {1'b0, u_r[N-1:1]};
        x1_nxt = {cout, sum[N-1:1]};
        if (u_r[1]) begin
          st_nxt = v_r[0] ? S_CMP : S_HALVE_V;
        end
      end
      S_HALVE_V: begin
        op_a   = x2_r;
        op_b   = x2_r[0] ? p_i : '0;
        v_nxt  = {1'b0, v_r[N-1:1]};
        x2_nxt = {cout, sum[N-1:1]};
        if (v_r[1]) begin
          st_nxt = S_CMP;
        end
      end
      // u - v; a borrow means v is larger
      S_CMP: begin
        op_a   = u_r;
        op_b   = v_r;
        op_sub = 1'b1;
        if (!cout) begin
          u_nxt   = sum;
          dir_nxt = 1'b0;
          st_nxt  = S_XSUB;
        end else begin
          st_nxt = S_SUBVU;
        end
      end
      S_SUBVU: begin
        op_a    = v_r;
        op_b    = u_r;
        op_sub  = 1'b1;
        v_nxt   = sum;
        dir_nxt = 1'b1;
        st_nxt  = S_XSUB;
      end
      // Modular subtract of the x values
      S_XSUB: begin
        op_a   = dir_r ? x2_r : x1_r;
        op_b   = dir_r ? x1_r : x2_r;
        op_sub = 1'b1;
        if (dir_r) x2_nxt = sum;
        else       x1_nxt = sum;
        st_nxt = cout ? S_XFIX : S_TEST;
      end
      S_XFIX: begin
        op_a = dir_r ? x2_r : x1_r;
        op_b = p_i;
        if (dir_r) x2_nxt = sum;
        else       x1_nxt = sum;
        st_nxt = S_TEST;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    u_r   <= u_nxt;
    v_r   <= v_nxt;
    x1_r  <= x1_nxt;
    x2_r  <= x2_nxt;
    dir_r <= dir_nxt;
  end

  assign x1_o = x1_r;

  `BMI_ASSERT_IMPL(a_halve_u_even, clk, rst_n, st_r == S_HALVE_U, !u_r[0])
  `BMI_ASSERT_IMPL(a_halve_v_even, clk, rst_n, st_r == S_HALVE_V, !v_r[0])
  `BMI_ASSERT_IMPL(a_subvu_after_cmp, clk, rst_n, st_r == S_SUBVU, $past(st_r) == S_CMP)
  `BMI_ASSERT_NEXT(a_done_to_idle, clk, rst_n, sts_o.done, st_r == S_IDLE)

endmodule
`default_nettype wire
